>>> src/rwslt_pkg.sv
// Package: shared constants, status codes and control structs of the slot lock table.
`timescale 1ns / 1ps
package rwslt_pkg;

   localparam int DEF_SLOT_COUNT        = 1024;
   localparam int DEF_MAX_KEYS          = 16;
   localparam int DEF_READER_COUNT_BITS = 16;

   localparam int HASH_W   = 64;
   localparam int CFG_W    = 4;
   localparam int STATUS_W = 2;
   localparam int MERGED_W = 5;

   localparam logic [CFG_W-1:0] SLOT_BITS_RESET = 4'd10;

   localparam logic [STATUS_W-1:0] ST_GRANTED  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_CONFLICT = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RELEASED = 2'd2;
   localparam logic [STATUS_W-1:0] ST_TOO_MANY = 2'd3;

   // controller -> datapath
   typedef struct packed {
      logic clr_wr;     // write zero at the sweep address, advance it
      logic key_load;   // merge the accepted key into the pending list
      logic walk_rst;   // walk index back to zero
      logic walk_inc;   // advance the walk index
      logic ent_load;   // latch the pending entry at the walk index
      logic rd_en;      // read the table at the latched slot
      logic exe;        // check or update with the read data
      logic commit;     // exe updates the table (else it only checks)
      logic resp_load;  // load the result register, end the transaction
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic clr_last;
      logic walk_last;
      logic overflow;
      logic release_op;
      logic conflict;
      logic rsp_busy;
   } stat_type;

endpackage

>>> src/rwslt_ctrl.sv
// Controller: sequences the clearing sweep, key loading and the walk over pending slots.
`timescale 1ns / 1ps
module rwslt_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_tlast,
   output logic                req_tready,
   input  rwslt_pkg::stat_type stat,
   output rwslt_pkg::cmd_type  cmd
);

   typedef enum logic [7:0] {
      S_CLEAR = 8'b0000_0001,
      S_IDLE  = 8'b0000_0010,
      S_DISP  = 8'b0000_0100,
      S_ADR   = 8'b0000_1000,
      S_RD    = 8'b0001_0000,
      S_EXE   = 8'b0010_0000,
      S_DEC   = 8'b0100_0000,
      S_DONE  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      commit_ff, commit_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         commit_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         commit_ff <= commit_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      commit_in  = commit_ff;
      cmd        = '0;
      cmd.commit = commit_ff;
      req_tready = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (stat.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.key_load = 1'b1;
               if (req_tlast) state_in = S_DISP;
            end
         end
         S_DISP: begin
            cmd.walk_rst = 1'b1;
            commit_in    = stat.release_op;
            state_in     = stat.overflow ? S_DONE : S_ADR;
         end
         S_ADR: begin
            cmd.ent_load = 1'b1;
            state_in     = S_RD;
         end
         S_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = S_EXE;
         end
         S_EXE: begin
            cmd.exe = 1'b1;
            if (stat.walk_last) begin
               state_in = commit_ff ? S_DONE : S_DEC;
            end else begin
               cmd.walk_inc = 1'b1;
               state_in     = S_ADR;
            end
         end
         S_DEC: begin
            // check pass over: take all slots only when none conflicted
            if (stat.conflict) begin
               state_in = S_DONE;
            end else begin
               commit_in    = 1'b1;
               cmd.walk_rst = 1'b1;
               state_in     = S_ADR;
            end
         end
         S_DONE: begin
            if (!stat.rsp_busy) begin
               cmd.resp_load = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

endmodule

>>> src/rwslt_dpath.sv
// Datapath: slot table memory, pending slot list, configuration and result register.
`timescale 1ns / 1ps
module rwslt_dpath #(
   parameter int SLOT_COUNT        = rwslt_pkg::DEF_SLOT_COUNT,
   parameter int MAX_KEYS          = rwslt_pkg::DEF_MAX_KEYS,
   parameter int READER_COUNT_BITS = rwslt_pkg::DEF_READER_COUNT_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  rwslt_pkg::cmd_type              cmd,
   output rwslt_pkg::stat_type             stat,
   input  logic                            req_func,
   input  logic                            req_write,
   input  logic [rwslt_pkg::HASH_W-1:0]    req_hash,
   input  logic                            csr_valid,
   input  logic [rwslt_pkg::CFG_W-1:0]     csr_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [rwslt_pkg::STATUS_W-1:0]  rsp_status,
   output logic [rwslt_pkg::MERGED_W-1:0]  rsp_merged
);

   localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int WB    = $clog2(SLOT_COUNT + 1) - 1;
   localparam int KI_W  = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
   localparam int CNT_W = $clog2(MAX_KEYS + 1);
   localparam int MW    = (CNT_W > rwslt_pkg::MERGED_W) ? CNT_W : rwslt_pkg::MERGED_W;
   localparam int RC    = READER_COUNT_BITS;

   // configuration
   logic [rwslt_pkg::CFG_W-1:0] cfg_ff;
   always_ff @(posedge clock) begin
      if (reset)          cfg_ff <= rwslt_pkg::SLOT_BITS_RESET;
      else if (csr_valid) cfg_ff <= csr_data;
   end

   logic [4:0]       bits_eff;
   logic [IDX_W-1:0] mask, slot;
   always_comb begin
      if (cfg_ff == '0)                  bits_eff = 5'd1;
      else if ({1'b0, cfg_ff} > 5'(WB))  bits_eff = 5'(WB);
      else                               bits_eff = {1'b0, cfg_ff};
      for (int b = 0; b < IDX_W; b++) mask[b] = (5'(b) < bits_eff);
      slot = req_hash[IDX_W-1:0] & mask;
   end

   // pending list
   logic [IDX_W-1:0] pend_slot_ff [MAX_KEYS];
   logic             pend_wr_ff   [MAX_KEYS];
   logic [CNT_W-1:0] count_ff;
   logic             overflow_ff, release_ff, conflict_ff;
   logic [MAX_KEYS-1:0] hit;

   always_comb begin
      for (int i = 0; i < MAX_KEYS; i++)
         hit[i] = (CNT_W'(i) < count_ff) && (pend_slot_ff[i] == slot);
   end

   always_ff @(posedge clock) begin
      if (cmd.key_load) begin
         for (int i = 0; i < MAX_KEYS; i++)
            if (hit[i] && req_write) pend_wr_ff[i] <= 1'b1;
         if (hit == '0 && count_ff < CNT_W'(MAX_KEYS)) begin
            pend_slot_ff[count_ff[KI_W-1:0]] <= slot;
            pend_wr_ff[count_ff[KI_W-1:0]]   <= req_write;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.resp_load) begin
         count_ff    <= '0;
         overflow_ff <= 1'b0;
      end else if (cmd.key_load && hit == '0) begin
         if (count_ff < CNT_W'(MAX_KEYS)) count_ff <= count_ff + CNT_W'(1);
         else                             overflow_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.key_load) release_ff <= req_func;
   end

   // counters
   logic [IDX_W-1:0] clr_ff;
   logic [KI_W-1:0]  walk_ff;
   always_ff @(posedge clock) begin
      if (reset)           clr_ff <= '0;
      else if (cmd.clr_wr) clr_ff <= clr_ff + IDX_W'(1);
      if (reset || cmd.walk_rst) walk_ff <= '0;
      else if (cmd.walk_inc)     walk_ff <= walk_ff + KI_W'(1);
   end

   // slot table: writer flag above the reader count
   logic [RC:0]      tbl [SLOT_COUNT];
   logic [IDX_W-1:0] ent_slot_ff;
   logic             ent_wr_ff;
   logic [RC:0]      rd_ff;
   logic             we;
   logic [IDX_W-1:0] wa;
   logic [RC:0]      wd;
   logic             chk_conf;
   logic             rd_w;
   logic [RC-1:0]    rd_c;

   always_ff @(posedge clock) begin
      if (cmd.ent_load) begin
         ent_slot_ff <= pend_slot_ff[walk_ff];
         ent_wr_ff   <= pend_wr_ff[walk_ff];
      end
      if (cmd.rd_en) rd_ff <= tbl[ent_slot_ff];
      if (we) tbl[wa] <= wd;
   end

   always_comb begin
      rd_w     = rd_ff[RC];
      rd_c     = rd_ff[RC-1:0];
      chk_conf = rd_w || (ent_wr_ff ? (rd_c != '0) : (&rd_c));
      we       = 1'b0;
      wa       = ent_slot_ff;
      wd       = rd_ff;
      if (cmd.clr_wr) begin
         we = 1'b1;
         wa = clr_ff;
         wd = '0;
      end else if (cmd.exe && cmd.commit) begin
         we = 1'b1;
         if (release_ff) begin
            if (ent_wr_ff)          wd = {1'b0, rd_c};
            else if (rd_c != '0)    wd = {rd_w, rd_c - RC'(1)};
         end else begin
            if (ent_wr_ff) wd = {1'b1, rd_c};
            else           wd = {rd_w, rd_c + RC'(1)};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.resp_load)          conflict_ff <= 1'b0;
      else if (cmd.exe && !cmd.commit && chk_conf) conflict_ff <= 1'b1;
   end

   // result register
   logic                           rsp_valid_ff;
   logic [rwslt_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [rwslt_pkg::MERGED_W-1:0] rsp_merged_ff;
   logic [MW-1:0]                  cnt_ext;
   assign cnt_ext = MW'(count_ff);

   always_ff @(posedge clock) begin
      if (reset)              rsp_valid_ff <= 1'b0;
      else if (cmd.resp_load) rsp_valid_ff <= 1'b1;
      else if (rsp_ready)     rsp_valid_ff <= 1'b0;
      if (cmd.resp_load) begin
         rsp_merged_ff <= cnt_ext[rwslt_pkg::MERGED_W-1:0];
         if (overflow_ff)      rsp_status_ff <= rwslt_pkg::ST_TOO_MANY;
         else if (release_ff)  rsp_status_ff <= rwslt_pkg::ST_RELEASED;
         else if (conflict_ff) rsp_status_ff <= rwslt_pkg::ST_CONFLICT;
         else                  rsp_status_ff <= rwslt_pkg::ST_GRANTED;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_merged = rsp_merged_ff;

   assign stat.clr_last   = (clr_ff == IDX_W'(SLOT_COUNT - 1));
   assign stat.walk_last  = ((CNT_W'(walk_ff) + CNT_W'(1)) == count_ff);
   assign stat.overflow   = overflow_ff;
   assign stat.release_op = release_ff;
   assign stat.conflict   = conflict_ff;
   assign stat.rsp_busy   = rsp_valid_ff && !rsp_ready;

endmodule

>>> src/reader_writer_slot_lock_table_top.sv
// Top level: reader/writer slot lock table with stream request and response channels.
//
//   channel | dir | handshake           | payload
//   req     | in  | req_tvalid/tready   | tdata lookup_hash, tuser {write_mode, func}, tlast
//   rsp     | out | rsp_tvalid/tready   | tdata merged_keys, tuser status
//   csr     | in  | csr_valid/ready     | csr_data slot_index_bits
//
// Keys are taken while the controller is idle. The closing key leads to a dispatch state,
// then the pending slots are walked through the table, each in address, read and execute
// states: one pass for a release; a check pass, a decision state and a commit pass for a
// granted acquire; then the result is loaded once the result register is free. Too many
// keys skips the walk. After reset a sweep writes zero to all SLOT_COUNT table entries,
// one a cycle, with req_tready low. A stalled result holds; keys are taken meanwhile.
`timescale 1ns / 1ps
module reader_writer_slot_lock_table_top #(
   parameter int SLOT_COUNT        = rwslt_pkg::DEF_SLOT_COUNT,
   parameter int MAX_KEYS          = rwslt_pkg::DEF_MAX_KEYS,
   parameter int READER_COUNT_BITS = rwslt_pkg::DEF_READER_COUNT_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [rwslt_pkg::HASH_W-1:0] req_tdata,   // [63:0] lookup_hash
   input  logic [1:0]                   req_tuser,   // [0] func, [1] write_mode
   input  logic                         req_tlast,   // last_key
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [7:0]                   rsp_tdata,   // [4:0] merged_keys, [7:5] zero
   output logic [rwslt_pkg::STATUS_W-1:0] rsp_tuser, // [1:0] status
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [rwslt_pkg::CFG_W-1:0]  csr_data
);

   rwslt_pkg::cmd_type  cmd;
   rwslt_pkg::stat_type stat;
   logic [rwslt_pkg::MERGED_W-1:0] merged;

   assign csr_ready = 1'b1;
   assign rsp_tdata = {3'b000, merged};

   rwslt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   rwslt_dpath #(
      .SLOT_COUNT        (SLOT_COUNT),
      .MAX_KEYS          (MAX_KEYS),
      .READER_COUNT_BITS (READER_COUNT_BITS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_func   (req_tuser[0]),
      .req_write  (req_tuser[1]),
      .req_hash   (req_tdata),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_status (rsp_tuser),
      .rsp_merged (merged)
   );

endmodule

>>> bench/reader_writer_slot_lock_table_top_test.sv
// Testbench: random and directed lock transactions against a predictive table model.
`timescale 1ns / 1ps
module reader_writer_slot_lock_table_top_test;

   localparam int SLOTS    = rwslt_pkg::DEF_SLOT_COUNT;
   localparam int KEYS_MAX = rwslt_pkg::DEF_MAX_KEYS;
   localparam int RD_MAX   = (1 << rwslt_pkg::DEF_READER_COUNT_BITS) - 1;
   localparam int WIDEST   = 10;
   localparam int STALL_LIMIT = 20000;

   localparam logic FN_ACQUIRE = 1'b0;
   localparam logic FN_RELEASE = 1'b1;

   typedef struct packed {
      logic        func;
      logic [63:0] hash;
      logic        wr;
      logic        last;
   } key_item_type;

   typedef struct packed {
      logic [1:0] status;
      logic [4:0] merged;
   } lock_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [63:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [3:0] csr_data = '0;

   reader_writer_slot_lock_table_top dut (.*);

   always #5 clock = ~clock;

   // predictor state
   int unsigned  readers [SLOTS];
   bit           writers [SLOTS];
   int unsigned  pend_slot [KEYS_MAX];
   bit           pend_wr [KEYS_MAX];
   int unsigned  pend_n;
   bit           overflowed;
   int unsigned  index_bits;

   key_item_type    key_queue[$];
   lock_result_type expected_results[$];
   int  errors = 0;
   bit  quiet_phase = 0;
   int  req_gap = 0, rsp_gap = 0, stall_cycles = 0;

   function automatic void predict_key(key_item_type k);
      int unsigned b, s, i;
      bit found, conflict;
      lock_result_type r;
      b = (index_bits < 1) ? 1 : (index_bits > WIDEST ? WIDEST : index_bits);
      s = int'(k.hash & ((64'd1 << b) - 1));
      found = 0;
      for (i = 0; i < pend_n; i++)
         if (!found && pend_slot[i] == s) begin
            if (k.wr) pend_wr[i] = 1;
            found = 1;
         end
      if (!found) begin
         if (pend_n < KEYS_MAX) begin
            pend_slot[pend_n] = s;
            pend_wr[pend_n] = k.wr;
            pend_n++;
         end else overflowed = 1;
      end
      if (!k.last) return;
      if (overflowed) r.status = rwslt_pkg::ST_TOO_MANY;
      else if (k.func == FN_RELEASE) begin
         for (i = 0; i < pend_n; i++)
            if (pend_wr[i]) writers[pend_slot[i]] = 0;
            else if (readers[pend_slot[i]] > 0) readers[pend_slot[i]]--;
         r.status = rwslt_pkg::ST_RELEASED;
      end else begin
         conflict = 0;
         for (i = 0; i < pend_n; i++)
            if (writers[pend_slot[i]]) conflict = 1;
            else if (pend_wr[i]) begin
               if (readers[pend_slot[i]] > 0) conflict = 1;
            end else if (readers[pend_slot[i]] >= RD_MAX) conflict = 1;
         if (conflict) r.status = rwslt_pkg::ST_CONFLICT;
         else begin
            for (i = 0; i < pend_n; i++)
               if (pend_wr[i]) writers[pend_slot[i]] = 1;
               else readers[pend_slot[i]]++;
            r.status = rwslt_pkg::ST_GRANTED;
         end
      end
      r.merged = pend_n[4:0];
      expected_results.push_back(r);
      pend_n = 0;
      overflowed = 0;
   endfunction

   // driver
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            predict_key({req_tuser[0], req_tdata, req_tuser[1], req_tlast});
            void'(key_queue.pop_front());
         end
         // hold a waiting transfer unchanged
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_gap <= req_gap - 1;
               req_tvalid <= 1'b0;
            end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
               req_gap <= $urandom_range(0, 7);
               req_tvalid <= 1'b0;
            end else if (key_queue.size() > 0) begin
               req_tvalid <= 1'b1;
               req_tdata  <= key_queue[0].hash;
               req_tuser  <= {key_queue[0].wr, key_queue[0].func};
               req_tlast  <= key_queue[0].last;
            end else req_tvalid <= 1'b0;
         end
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            lock_result_type e;
            if (expected_results.size() == 0) begin
               $error("unexpected result status=%0d merged_keys=%0d",
                      rsp_tuser, rsp_tdata[4:0]);
               errors++;
            end else begin
               e = expected_results.pop_front();
               if (rsp_tuser !== e.status) begin
                  $error("status expected %0d actual %0d", e.status, rsp_tuser);
                  errors++;
               end
               if (rsp_tdata[4:0] !== e.merged) begin
                  $error("merged_keys expected %0d actual %0d", e.merged, rsp_tdata[4:0]);
                  errors++;
               end
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_tready <= 1'b0;
         end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
            rsp_gap <= $urandom_range(0, 7);
            rsp_tready <= 1'b0;
         end else rsp_tready <= 1'b1;
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
             || (csr_valid && csr_ready))
            stall_cycles <= 0;
         else stall_cycles <= stall_cycles + 1;
      end
   end

   always @(posedge clock)
      if (stall_cycles >= STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end

   task automatic add_key(logic func, logic [63:0] hash, logic wr, logic last);
      key_item_type k;
      k.func = func; k.hash = hash; k.wr = wr; k.last = last;
      key_queue.push_back(k);
   endtask

   // random transaction: mostly few keys in a narrow slot range
   task automatic add_transaction(int unsigned nkeys, logic func, int unsigned span);
      logic [63:0] h;
      logic        fn;
      for (int i = 0; i < nkeys; i++) begin
         h = {$urandom, $urandom};
         h[9:0] = 10'($urandom_range(0, span));
         // only the closing key's func counts
         fn = (i == nkeys - 1) ? func : 1'($urandom_range(0, 1));
         add_key(fn, h, 1'($urandom_range(0, 2) == 0), 1'(i == nkeys - 1));
      end
   endtask

   task automatic drain();
      wait (key_queue.size() == 0);
      @(posedge clock);
      while (req_tvalid || expected_results.size() != 0) @(posedge clock);
      // settle before the register changes
      repeat (120) @(posedge clock);
   endtask

   task automatic write_bits(logic [3:0] v);
      csr_valid <= 1'b1;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      index_bits = v;
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [3:0] settings [6] = '{4'd0, 4'd1, 4'd15, 4'd3, 4'd10, 4'd6};
      for (int i = 0; i < SLOTS; i++) begin
         readers[i] = 0;
         writers[i] = 0;
      end
      pend_n = 0;
      overflowed = 0;
      index_bits = rwslt_pkg::SLOT_BITS_RESET;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, merging, conflicts, releases of unheld locks, overflow
      add_key(FN_ACQUIRE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1);
      add_key(FN_ACQUIRE, 64'h0000_0000_0000_03FF, 1'b0, 1'b1);
      add_key(FN_RELEASE, 64'h0, 1'b1, 1'b0);
      add_key(FN_RELEASE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1);
      add_key(FN_ACQUIRE, 64'h5, 1'b0, 1'b0);
      add_key(FN_RELEASE, 64'h5, 1'b1, 1'b1);
      add_key(FN_ACQUIRE, 64'h5, 1'b0, 1'b1);
      add_key(FN_ACQUIRE, 64'h5, 1'b0, 1'b1);
      add_key(FN_ACQUIRE, 64'h5, 1'b1, 1'b1);
      add_key(FN_RELEASE, 64'h5, 1'b0, 1'b1);
      add_key(FN_RELEASE, 64'h5, 1'b0, 1'b1);
      add_key(FN_RELEASE, 64'h5, 1'b0, 1'b1);
      add_key(FN_ACQUIRE, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 1'b1);
      for (int i = 0; i < 17; i++)
         add_key(FN_RELEASE, 64'h100 + i, 1'b0, 1'(i == 16));
      drain();

      for (int p = 0; p < 6; p++) begin
         write_bits(settings[p]);
         if (p == 5) quiet_phase = 1;
         for (int t = 0; t < 80; t++) begin
            int unsigned n;
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 18) : $urandom_range(1, 4);
            add_transaction(n, $urandom_range(0, 2) == 0 ? FN_RELEASE : FN_ACQUIRE,
                            $urandom_range(0, 3) == 0 ? 1023 : 15);
            // open the next transaction with an extra top-slot key
            if (p == 2 && t == 40) begin
               add_key(FN_ACQUIRE, 64'h3FF, 1'b0, 1'b0);
            end
         end
         drain();
      end

      if (errors == 0 && expected_results.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end
endmodule

>>> filelist.f
src/rwslt_pkg.sv
src/rwslt_ctrl.sv
src/rwslt_dpath.sv
src/reader_writer_slot_lock_table_top.sv
bench/reader_writer_slot_lock_table_top_test.sv
